// ----- design/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is asserted
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/qmpa_pkg.sv -----
`default_nettype none

package qmpa_pkg;

  localparam int unsigned NUM_MOTORS = 4;
  localparam int unsigned NUM_TERMS  = 4;
  localparam int unsigned TERM_W     = 48;   // gain*input floored to Q.24
  localparam int unsigned SUM_W      = 50;
  localparam int unsigned FRAC_W     = 42;   // fraction saturated to +-2^40
  localparam int unsigned SPAN_W     = 17;
  localparam int unsigned PROD_W     = FRAC_W + SPAN_W;
  localparam int unsigned RAW_W      = PROD_W + 1;
  localparam int unsigned PWM_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRUST_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PWM     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_PWM     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START_PWMS  = 3'd5;

  localparam logic [PWM_W-1:0] MAX_PWM_RST    = 16'd2000;
  localparam logic [PWM_W-1:0] SAT_PWM_RST    = 16'd2000;
  localparam logic [63:0]      START_PWMS_RST = 64'h03E8_03E8_03E8_03E8;

  localparam logic signed [SUM_W-1:0] FRAC_LIMIT = SUM_W'(64'sd1 <<< 40);

  // Term order: 0 thrust, 1 roll, 2 pitch, 3 yaw
  typedef logic signed [TERM_W-1:0] term_t;
  typedef term_t [NUM_TERMS-1:0] term_vec_t;
  typedef logic [PWM_W-1:0] pwm_t;
  typedef pwm_t [NUM_MOTORS-1:0] pwm_vec_t;

  typedef struct packed {
    logic ld_mix;    // load the saturated fraction
    logic ld_scale;  // load fraction * span
  } lane_ctl_t;

  // Set bit means subtract that term for the motor
  function automatic logic [NUM_TERMS-1:0] mix_sub_mask(input logic [1:0] motor);
    logic [NUM_TERMS-1:0] m;
    case (motor)
      2'd0:    m = 4'b1000;  // +T +R +P -Y
      2'd1:    m = 4'b0010;  // +T -R +P +Y
      2'd2:    m = 4'b1110;  // +T -R -P -Y
      2'd3:    m = 4'b0100;  // +T +R -P +Y
      default: m = 4'b0000;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- design/qmpa_front.sv -----
`default_nettype none

module qmpa_front
  import qmpa_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               ld,
  input  wire logic signed [31:0] thrust_gain,
  input  wire logic signed [31:0] tilt_gain,
  input  wire logic signed [31:0] yaw_gain,
  input  wire logic signed [31:0] u_thrust,
  input  wire logic signed [31:0] u_roll,
  input  wire logic signed [31:0] u_pitch,
  input  wire logic signed [31:0] u_yaw,
  output term_vec_t               terms
);

  logic signed [63:0] prod_t, prod_r_w, prod_p, prod_y;
  term_vec_t          terms_r;

  assign prod_t   = thrust_gain * u_thrust;
  assign prod_r_w = tilt_gain * u_roll;
  assign prod_p   = tilt_gain * u_pitch;
  assign prod_y   = yaw_gain * u_yaw;

  // Dropping the low 16 bits floors Q24.40 to Q.24
  always_ff @(posedge clk) begin
    if (ld) begin
      terms_r[0] <= prod_t[63:16];
      terms_r[1] <= prod_r_w[63:16];
      terms_r[2] <= prod_p[63:16];
      terms_r[3] <= prod_y[63:16];
    end
  end

  assign terms = terms_r;

endmodule

`default_nettype wire

// ----- design/qmpa_lane.sv -----
`default_nettype none

module qmpa_lane
  import qmpa_pkg::*;
(
  input  wire logic                 clk,
  input  wire lane_ctl_t            ctl,
  input  wire term_vec_t            terms,
  input  wire logic [NUM_TERMS-1:0] sub_mask,
  input  wire logic [PWM_W-1:0]     max_pwm,
  input  wire logic [PWM_W-1:0]     sat_pwm,
  input  wire logic [PWM_W-1:0]     start_pwm,
  output pwm_t                      pwm
);

  logic signed [SUM_W-1:0]  sum;
  logic signed [FRAC_W-1:0] frac_nxt, frac_r;
  logic signed [SPAN_W-1:0] span;
  logic signed [PROD_W-1:0] prod_nxt, prod_r;
  logic signed [RAW_W-1:0]  raw, start_q24, sat_q24;

  always_comb begin
    sum = '0;
    for (int k = 0; k < NUM_TERMS; k++) begin
      if (sub_mask[k]) sum = sum - SUM_W'(terms[k]);
      else             sum = sum + SUM_W'(terms[k]);
    end
    if (sum > FRAC_LIMIT)       frac_nxt = FRAC_W'(FRAC_LIMIT);
    else if (sum < -FRAC_LIMIT) frac_nxt = FRAC_W'(-FRAC_LIMIT);
    else                        frac_nxt = sum[FRAC_W-1:0];
  end

  assign span     = $signed({1'b0, max_pwm}) - $signed({1'b0, start_pwm});
  assign prod_nxt = frac_r * span;

  always_ff @(posedge clk) begin
    if (ctl.ld_mix)   frac_r <= frac_nxt;
    if (ctl.ld_scale) prod_r <= prod_nxt;
  end

  assign start_q24 = $signed({(RAW_W-PWM_W-24)'(0), start_pwm, 24'd0});
  assign sat_q24   = $signed({(RAW_W-PWM_W-24)'(0), sat_pwm, 24'd0});
  assign raw       = RAW_W'(prod_r) + start_q24;

  // Saturation wins over the start floor; otherwise round half up
  always_comb begin
    if (raw > sat_q24)        pwm = sat_pwm;
    else if (prod_r < 0)      pwm = start_pwm;
    else                      pwm = raw[24+PWM_W-1:24] + PWM_W'(raw[23]);
  end

endmodule

`default_nettype wire

// ----- design/qmpa_merge.sv -----
`default_nettype none

module qmpa_merge
  import qmpa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     ld,
  input  wire pwm_vec_t lane_pwm,
  output pwm_vec_t      out_pwm
);

  pwm_vec_t pwm_r;

  // Collect all four lanes into one result word
  always_ff @(posedge clk) begin
    if (ld) begin
      for (int m = 0; m < NUM_MOTORS; m++) pwm_r[m] <= lane_pwm[m];
    end
  end

  assign out_pwm = pwm_r;

endmodule

`default_nettype wire

// ----- design/quad_mixer_pwm_allocator_unit.sv -----
// X-quad motor mixer: thrust, roll, pitch and yaw commands in, four motor
// pulse widths out.
// Channels: in_* carries one command (four Q16.16 values) under in_valid and
// in_ready; out_* carries the four pulse widths under out_valid and out_ready.
// cfg_* writes one register per transfer (index 0..5, others ignored); it is
// always ready and must only be used while no command is in flight.
// One command per cycle passes while the output is not stalled, through the
// four-stage pipeline (gain multiply, mix and saturate, span multiply,
// clamp/round into the output register).
// Each pipeline stage has its own valid bit, so a stalled output blocks only
// once every stage is full; bubbles ahead of it still take new commands.
// Reset: gains go to zero, max and saturation to 2000 us, every start to
// 1000 us, and the pipeline empties.
`default_nettype none

`include "assert_macros.svh"

module quad_mixer_pwm_allocator_unit
  import qmpa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic signed [31:0]   in_u_thrust,
  input  wire logic signed [31:0]   in_u_roll,
  input  wire logic signed [31:0]   in_u_pitch,
  input  wire logic signed [31:0]   in_u_yaw,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [PWM_W-1:0]          out_motor1_pwm,
  output logic [PWM_W-1:0]          out_motor2_pwm,
  output logic [PWM_W-1:0]          out_motor3_pwm,
  output logic [PWM_W-1:0]          out_motor4_pwm,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]          cfg_data
);

  logic signed [31:0] thrust_gain_r, tilt_gain_r, yaw_gain_r;
  logic [PWM_W-1:0]   max_pwm_r, sat_pwm_r;
  logic [63:0]        start_pwms_r;

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;
  logic ld1, ld4;
  lane_ctl_t ctl;

  term_vec_t terms;
  pwm_vec_t  lane_pwm, out_pwm;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thrust_gain_r <= '0;
      tilt_gain_r   <= '0;
      yaw_gain_r    <= '0;
      max_pwm_r     <= MAX_PWM_RST;
      sat_pwm_r     <= SAT_PWM_RST;
      start_pwms_r  <= START_PWMS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_THRUST_GAIN: thrust_gain_r <= cfg_data[31:0];
        REG_TILT_GAIN:   tilt_gain_r   <= cfg_data[31:0];
        REG_YAW_GAIN:    yaw_gain_r    <= cfg_data[31:0];
        REG_MAX_PWM:     max_pwm_r     <= cfg_data[PWM_W-1:0];
        REG_SAT_PWM:     sat_pwm_r     <= cfg_data[PWM_W-1:0];
        REG_START_PWMS:  start_pwms_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage takes new data when it is empty or its content moves on
  assign rdy4 = !v4_r || out_ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_ready = rdy1;
  assign ld1      = in_valid && rdy1;
  assign ctl      = '{ld_mix: v1_r && rdy2, ld_scale: v2_r && rdy3};
  assign ld4      = v3_r && rdy4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  qmpa_front u_front (
    .clk         (clk),
    .ld          (ld1),
    .thrust_gain (thrust_gain_r),
    .tilt_gain   (tilt_gain_r),
    .yaw_gain    (yaw_gain_r),
    .u_thrust    (in_u_thrust),
    .u_roll      (in_u_roll),
    .u_pitch     (in_u_pitch),
    .u_yaw       (in_u_yaw),
    .terms       (terms)
  );

  for (genvar m = 0; m < NUM_MOTORS; m++) begin : g_lane
    qmpa_lane u_lane (
      .clk       (clk),
      .ctl       (ctl),
      .terms     (terms),
      .sub_mask  (mix_sub_mask(2'(m))),
      .max_pwm   (max_pwm_r),
      .sat_pwm   (sat_pwm_r),
      .start_pwm (start_pwms_r[PWM_W*m +: PWM_W]),
      .pwm       (lane_pwm[m])
    );
  end

  qmpa_merge u_merge (
    .clk      (clk),
    .ld       (ld4),
    .lane_pwm (lane_pwm),
    .out_pwm  (out_pwm)
  );

  assign out_valid      = v4_r;
  assign out_motor1_pwm = out_pwm[0];
  assign out_motor2_pwm = out_pwm[1];
  assign out_motor3_pwm = out_pwm[2];
  assign out_motor4_pwm = out_pwm[3];

  `ASSERT_IMPLIES(a_full_when_blocked, clk, rst_n, !in_ready, v1_r && v2_r && v3_r && v4_r && !out_ready, "input blocked with a free stage")
  `ASSERT_NEXT(a_no_repeat, clk, rst_n, out_valid && out_ready && !v3_r, !out_valid, "result repeated after transfer")
  `ASSERT_NEXT(a_load_sets_valid, clk, rst_n, ld1, v1_r, "accepted command lost at stage one")

  for (genvar m = 0; m < NUM_MOTORS; m++) begin : g_chk
    `ASSERT_IMPLIES(a_pwm_clamped, clk, rst_n, out_valid, out_pwm[m] == sat_pwm_r || out_pwm[m] == start_pwms_r[PWM_W*m +: PWM_W] || (out_pwm[m] > start_pwms_r[PWM_W*m +: PWM_W] && out_pwm[m] < sat_pwm_r), "pulse width outside clamp window")
  end

endmodule

`default_nettype wire
